[design/ets_pkg.sv]
// ----------------------------------------------------------------------------
// ets_pkg
// Shared constants, reciprocal multipliers, month table and the pipeline
// control type of the epoch-seconds to calendar converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ets_pkg;

	// Register stages from the input register to the result register
	localparam int STAGES = 7;

	// Midnight alignment and the last representable instant (2099-12-31 23:59:59)
	localparam logic [32:0] NOON_SHIFT          = 33'd43200;
	localparam logic [31:0] LAST_VALID_SECONDS  = 32'd3155716799;
	localparam logic [11:0] BASE_YEAR           = 12'd2000;

	// Day split: 86400 = 2^7 * 675, the 2^7 part is a shift
	localparam int          DAY_SHIFT_LO  = 7;
	localparam logic [9:0]  DAY_DIV_HI    = 10'd675;
	localparam int          DAY_RCP_SHIFT = 36;
	localparam logic [26:0] DAY_RECIP     =
		27'(((64'd1 << DAY_RCP_SHIFT) + 64'd674) / 64'd675);

	// Four-year cycle split of a 16-bit day count
	localparam logic [10:0] DAYS_PER_CYCLE  = 11'd1461;
	localparam int          CYC_RCP_SHIFT   = 27;
	localparam logic [16:0] CYCLE_RECIP     =
		17'(((64'd1 << CYC_RCP_SHIFT) + 64'd1460) / 64'd1461);

	// Year boundaries inside a cycle (leap year first)
	localparam logic [10:0] YEAR1_START = 11'd366;
	localparam logic [10:0] YEAR2_START = 11'd731;
	localparam logic [10:0] YEAR3_START = 11'd1096;

	// Hour split: 3600 = 2^4 * 225
	localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
	localparam int          HOUR_RCP_SHIFT = 21;
	localparam logic [13:0] HOUR_RECIP    =
		14'(((64'd1 << HOUR_RCP_SHIFT) + 64'd224) / 64'd225);

	// Minute split: 60 = 2^2 * 15
	localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
	localparam int          MIN_RCP_SHIFT = 14;
	localparam logic [10:0] MIN_RECIP     =
		11'(((64'd1 << MIN_RCP_SHIFT) + 64'd14) / 64'd15);

	// First day of year of each month, February stretched in a leap year
	function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
		logic [8:0] base;
		unique case (m)
			4'd0:    base = 9'd0;
			4'd1:    base = 9'd31;
			4'd2:    base = 9'd59;
			4'd3:    base = 9'd90;
			4'd4:    base = 9'd120;
			4'd5:    base = 9'd151;
			4'd6:    base = 9'd181;
			4'd7:    base = 9'd212;
			4'd8:    base = 9'd243;
			4'd9:    base = 9'd273;
			4'd10:   base = 9'd304;
			4'd11:   base = 9'd334;
			default: base = 9'd0;
		endcase
		return base + ((leap && (m >= 4'd2)) ? 9'd1 : 9'd0);
	endfunction

	// Stage load enables from the pipeline control to the datapath
	typedef struct packed {
		logic [STAGES-1:0] en;
	} ets_ctrl_t;

endpackage

[design/ets_if.sv]
// ----------------------------------------------------------------------------
// ets_if
// Request channels of the converter: timestamp in, calendar fields out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ets_stamp_if;
	logic        valid;
	logic        ready;
	logic [31:0] epoch_seconds;

	modport source (output valid, output epoch_seconds, input ready);
	modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface ets_cal_if;
	logic        valid;
	logic        ready;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day_of_month;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;
	logic        out_of_range;

	modport source (output valid, output year, output month, output day_of_month,
		output hour, output minute, output second, output out_of_range, input ready);
	modport sink   (input valid, input year, input month, input day_of_month,
		input hour, input minute, input second, input out_of_range, output ready);
endinterface

[design/ets_pipe_ctrl.sv]
// ----------------------------------------------------------------------------
// ets_pipe_ctrl
// Valid bits of the stages and per-stage load enables; a stage moves when it
// is empty or the stage after it moves, so bubbles close up under a stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ets_pipe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output ets_pkg::ets_ctrl_t ctrl
);
	import ets_pkg::*;

	logic [STAGES-1:0] valid_q;
	logic [STAGES-1:0] adv;
	logic [STAGES-1:0] valid_nxt;

	// Advance chain from the output back to the input
	always_comb begin
		adv[STAGES-1] = !valid_q[STAGES-1] || out_ready;
		for (int k = STAGES - 2; k >= 0; k--) begin
			adv[k] = !valid_q[k] || adv[k+1];
		end
	end

	// Next valid bits
	always_comb begin
		valid_nxt[0] = adv[0] ? in_valid : valid_q[0];
		for (int k = 1; k < STAGES; k++) begin
			valid_nxt[k] = adv[k] ? valid_q[k-1] : valid_q[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= valid_nxt;
		end
	end

	assign ctrl.en   = adv;
	assign in_ready  = adv[0];
	assign out_valid = valid_q[STAGES-1];

	// A full stage is never loaded unless its content moves on
	for (genvar k = 0; k < STAGES - 1; k++) begin : g_no_overwrite
		a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
			(adv[k] && valid_q[k]) |-> adv[k+1])
			else $error("stage %0d overwritten while full", k);
	end

	// An empty first stage always takes a request
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_q[0] |-> in_ready)
		else $error("input stalled with empty first stage");

	// A delivered result with nothing behind it leaves the output empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q[STAGES-1] && out_ready && !valid_q[STAGES-2]) |=> !out_valid)
		else $error("result repeated after delivery");

endmodule

[design/ets_datapath.sv]
// ----------------------------------------------------------------------------
// ets_datapath
// Stage registers and arithmetic: day split, four-year cycle split, time of
// day split, year of cycle, month lookup. Divisions by constants are exact
// reciprocal multiplies, each followed by a back-multiply for the remainder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ets_datapath (
	input  logic               clk,
	input  ets_pkg::ets_ctrl_t ctrl,
	input  logic [31:0]        epoch_seconds,
	output logic [11:0]        year,
	output logic [3:0]         month,
	output logic [4:0]         day_of_month,
	output logic [4:0]         hour,
	output logic [5:0]         minute,
	output logic [5:0]         second,
	output logic               out_of_range
);
	import ets_pkg::*;

	// Stage 1: input register
	logic [31:0] secs_s1;

	logic [32:0] t1;
	logic [25:0] n1;
	logic [52:0] prod1;
	logic [15:0] days1;
	logic        oor1;

	// Stage 2
	logic [15:0] days_s2;
	logic [25:0] n_s2;
	logic [6:0]  tlow_s2;
	logic        oor_s2;

	logic [25:0] dprod2;
	logic [25:0] nr2;
	logic [16:0] sod2;

	// Stage 3
	logic [15:0] days_s3;
	logic [16:0] sod_s3;
	logic        oor_s3;

	logic [32:0] cprod3;
	logic [26:0] hprod3;

	// Stage 4
	logic [15:0] days_s4;
	logic [16:0] sod_s4;
	logic [5:0]  cycle_s4;
	logic [4:0]  hour_s4;
	logic        oor_s4;

	logic [15:0] rest4;
	logic [16:0] remh4;

	// Stage 5
	logic [10:0] rest_s5;
	logic [11:0] remh_s5;
	logic [5:0]  cycle_s5;
	logic [4:0]  hour_s5;
	logic        oor_s5;

	logic [1:0]  yoff5;
	logic [10:0] doy5;
	logic [20:0] mprod5;

	// Stage 6
	logic [1:0]  yoff_s6;
	logic [8:0]  doy_s6;
	logic [11:0] remh_s6;
	logic [5:0]  cycle_s6;
	logic [4:0]  hour_s6;
	logic [5:0]  min_s6;
	logic        oor_s6;

	logic        leap6;
	logic [3:0]  mon_idx6;
	logic [8:0]  dom_off6;
	logic [11:0] year6;
	logic [11:0] sprod6;
	logic [11:0] sec6;

	// Stage 7: result register
	logic [11:0] year_s7;
	logic [3:0]  month_s7;
	logic [4:0]  dom_s7;
	logic [4:0]  hour_s7;
	logic [5:0]  min_s7;
	logic [5:0]  sec_s7;
	logic        oor_s7;

	// Midnight-aligned count, days = (t >> 7) / 675
	assign t1    = {1'b0, secs_s1} + NOON_SHIFT;
	assign n1    = t1[32:DAY_SHIFT_LO];
	assign prod1 = 53'(n1) * 53'(DAY_RECIP);
	assign days1 = prod1[DAY_RCP_SHIFT+15:DAY_RCP_SHIFT];
	assign oor1  = secs_s1 > LAST_VALID_SECONDS;

	// Seconds of the day from the remainder
	assign dprod2 = 26'(days_s2) * 26'(DAY_DIV_HI);
	assign nr2    = n_s2 - dprod2;
	assign sod2   = {nr2[9:0], tlow_s2};

	// Cycle number and hour of day
	assign cprod3 = 33'(days_s3) * 33'(CYCLE_RECIP);
	assign hprod3 = 27'(sod_s3[16:4]) * 27'(HOUR_RECIP);

	// Day of cycle and seconds within the hour
	assign rest4 = days_s4 - 16'(cycle_s4) * 16'(DAYS_PER_CYCLE);
	assign remh4 = sod_s4 - 17'(hour_s4) * 17'(SECS_PER_HOUR);

	// Year of cycle; the leap year comes first
	always_comb begin
		priority if (rest_s5 < YEAR1_START) begin
			yoff5 = 2'd0;
			doy5  = rest_s5;
		end else if (rest_s5 < YEAR2_START) begin
			yoff5 = 2'd1;
			doy5  = rest_s5 - YEAR1_START;
		end else if (rest_s5 < YEAR3_START) begin
			yoff5 = 2'd2;
			doy5  = rest_s5 - YEAR2_START;
		end else begin
			yoff5 = 2'd3;
			doy5  = rest_s5 - YEAR3_START;
		end
	end

	// Minute = (seconds in hour >> 2) / 15
	assign mprod5 = 21'(remh_s5[11:2]) * 21'(MIN_RECIP);

	// Month: last month whose first day is not past the day of year
	assign leap6 = (yoff_s6 == 2'd0);

	always_comb begin
		mon_idx6 = 4'd0;
		for (int m = 1; m < 12; m++) begin
			if (doy_s6 >= month_start(4'(m), leap6)) begin
				mon_idx6 = 4'(m);
			end
		end
		dom_off6 = doy_s6 - month_start(mon_idx6, leap6);
	end

	assign year6  = BASE_YEAR + {4'd0, cycle_s6, 2'b00} + {10'd0, yoff_s6};
	assign sprod6 = 12'(min_s6) * 12'(SECS_PER_MIN);
	assign sec6   = remh_s6 - sprod6;

	// Stage registers
	always_ff @(posedge clk) begin
		if (ctrl.en[0]) begin
			secs_s1 <= epoch_seconds;
		end
		if (ctrl.en[1]) begin
			days_s2 <= days1;
			n_s2    <= n1;
			tlow_s2 <= t1[DAY_SHIFT_LO-1:0];
			oor_s2  <= oor1;
		end
		if (ctrl.en[2]) begin
			days_s3 <= days_s2;
			sod_s3  <= sod2;
			oor_s3  <= oor_s2;
		end
		if (ctrl.en[3]) begin
			days_s4  <= days_s3;
			sod_s4   <= sod_s3;
			cycle_s4 <= cprod3[CYC_RCP_SHIFT+5:CYC_RCP_SHIFT];
			hour_s4  <= hprod3[HOUR_RCP_SHIFT+4:HOUR_RCP_SHIFT];
			oor_s4   <= oor_s3;
		end
		if (ctrl.en[4]) begin
			rest_s5  <= rest4[10:0];
			remh_s5  <= remh4[11:0];
			cycle_s5 <= cycle_s4;
			hour_s5  <= hour_s4;
			oor_s5   <= oor_s4;
		end
		if (ctrl.en[5]) begin
			yoff_s6  <= yoff5;
			doy_s6   <= doy5[8:0];
			remh_s6  <= remh_s5;
			cycle_s6 <= cycle_s5;
			hour_s6  <= hour_s5;
			min_s6   <= mprod5[MIN_RCP_SHIFT+5:MIN_RCP_SHIFT];
			oor_s6   <= oor_s5;
		end
		if (ctrl.en[6]) begin
			// date fields read zero past the range
			year_s7  <= oor_s6 ? 12'd0 : year6;
			month_s7 <= oor_s6 ? 4'd0 : mon_idx6 + 4'd1;
			dom_s7   <= oor_s6 ? 5'd0 : 5'(dom_off6 + 9'd1);
			hour_s7  <= hour_s6;
			min_s7   <= min_s6;
			sec_s7   <= sec6[5:0];
			oor_s7   <= oor_s6;
		end
	end

	assign year         = year_s7;
	assign month        = month_s7;
	assign day_of_month = dom_s7;
	assign hour         = hour_s7;
	assign minute       = min_s7;
	assign second       = sec_s7;
	assign out_of_range = oor_s7;

endmodule

[design/epoch_seconds_to_calendar.sv]
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts whole seconds since 2000-01-01 12:00 into year, month, day, hour,
// minute and second, valid through 2099-12-31 23:59:59. Later inputs raise
// out_of_range and read zero in the date fields while the time of day stays
// valid. The block takes one request per clock cycle while the output is not
// stalled and delivers each result in order; the seven stages are set by the
// chain of reciprocal multiplies for the splits by 86400, 1461, 3600 and 60.
// A stalled result holds the last stage while earlier empty stages keep
// accepting requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epoch_seconds_to_calendar (
	input  logic      clk,
	input  logic      arst_n,
	ets_stamp_if.sink stamp,
	ets_cal_if.source calendar
);
	import ets_pkg::*;

	ets_ctrl_t ctrl;

	// Stage valid bits and load enables
	ets_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (stamp.valid),
		.in_ready  (stamp.ready),
		.out_valid (calendar.valid),
		.out_ready (calendar.ready),
		.ctrl      (ctrl)
	);

	// Conversion stages
	ets_datapath u_dp (
		.clk           (clk),
		.ctrl          (ctrl),
		.epoch_seconds (stamp.epoch_seconds),
		.year          (calendar.year),
		.month         (calendar.month),
		.day_of_month  (calendar.day_of_month),
		.hour          (calendar.hour),
		.minute        (calendar.minute),
		.second        (calendar.second),
		.out_of_range  (calendar.out_of_range)
	);

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench of the epoch-seconds to calendar converter. A short table of
// timestamps covers the epoch, midnight and leap-day edges and the top of the
// range; random timestamps follow. A local calendar predictor gives the
// expected fields where the table gives none, and every result is checked in
// order. Both sides idle at random, and the output is held off once for a
// long stretch so that the pipeline fills and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import ets_pkg::*;

	localparam longint unsigned SECS_PER_MINUTE = 60;
	localparam longint unsigned SECS_PER_HOUR_L = 3600;
	localparam longint unsigned HOURS_IN_DAY    = 24;
	localparam longint unsigned SECS_IN_DAY     = 86400;
	localparam longint unsigned MIDNIGHT_OFFSET = 43200;
	localparam longint unsigned DAYS_IN_CYCLE   = 1461;
	localparam longint unsigned DAYS_LEAP_YEAR  = 366;
	localparam longint unsigned DAYS_COMMON     = 365;
	localparam int              LAST_DAY        = 36525;

	localparam int IDLE_PERCENT   = 23;
	localparam int HOLD_CYCLES    = 80;
	localparam int DRAIN_CYCLES   = 20;
	localparam int CYCLE_LIMIT    = 200000;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day_of_month;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic        out_of_range;
	} calendar_t;

	typedef struct packed {
		logic [31:0] secs;
		logic        typed;
		calendar_t   want;
	} stamp_row_t;

	logic clk;
	logic arst_n;

	ets_stamp_if stamp_ch ();
	ets_cal_if   cal_ch ();

	epoch_seconds_to_calendar DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.stamp    (stamp_ch),
		.calendar (cal_ch)
	);

	calendar_t  pending_calendars [$];
	stamp_row_t directed_rows [$];
	int         mismatch_count;
	int         stamps_sent;
	int         dates_checked;
	int         late_stamps;
	int         leap_days;
	int         cycle_count;
	bit         calm;
	bit         hold_outputs;

	// Clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watchdog
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_calendars.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Days in month m (1..12)
	function automatic longint unsigned month_length(input int m, input logic leap);
		case (m)
			2:            return leap ? 29 : 28;
			4, 6, 9, 11:  return 30;
			default:      return 31;
		endcase
	endfunction

	// Calendar predictor
	function automatic calendar_t calendar_of(input logic [31:0] secs);
		calendar_t       c;
		longint unsigned t;
		longint unsigned days;
		longint unsigned rest;
		longint unsigned yoff;
		longint unsigned doy;
		longint unsigned yr;
		logic            leap;
		logic            found;
		int              m;
		c = '0;
		t = {32'd0, secs} + MIDNIGHT_OFFSET;
		c.second = 6'(t % SECS_PER_MINUTE);
		c.minute = 6'((t / SECS_PER_MINUTE) % SECS_PER_MINUTE);
		c.hour = 5'((t / SECS_PER_HOUR_L) % HOURS_IN_DAY);
		c.out_of_range = secs > LAST_VALID_SECONDS;
		if (!c.out_of_range) begin
			days = t / SECS_IN_DAY;
			rest = days % DAYS_IN_CYCLE;
			// leap year opens each four-year cycle
			if (rest < DAYS_LEAP_YEAR) begin
				yoff = 0;
				doy = rest;
			end else begin
				yoff = 1 + (rest - DAYS_LEAP_YEAR) / DAYS_COMMON;
				doy = (rest - DAYS_LEAP_YEAR) % DAYS_COMMON;
			end
			yr = BASE_YEAR + 4 * (days / DAYS_IN_CYCLE) + yoff;
			leap = (yr % 4) == 0;
			c.year = 12'(yr);
			found = 1'b0;
			for (m = 1; m <= 12; m++) begin
				if (!found) begin
					if (doy < month_length(m, leap)) begin
						c.month = 4'(m);
						c.day_of_month = 5'(doy + 1);
						found = 1'b1;
					end else begin
						doy -= month_length(m, leap);
					end
				end
			end
		end
		return c;
	endfunction

	function automatic calendar_t date_of(input int y, input int mo, input int d,
			input int h, input int mi, input int s, input logic oor);
		return {12'(y), 4'(mo), 5'(d), 5'(h), 6'(mi), 6'(s), oor};
	endfunction

	task automatic add_row(input logic [31:0] secs, input logic typed, input calendar_t want);
		directed_rows.push_back({secs, typed, want});
	endtask

	// Random timestamp, weighted toward the valid range and day edges
	function automatic logic [31:0] pick_stamp();
		int unsigned kind;
		longint      day_start;
		kind = $urandom_range(99);
		if (kind < 60)
			return $urandom_range(LAST_VALID_SECONDS);
		if (kind < 80) begin
			day_start = longint'($urandom_range(LAST_DAY)) * SECS_IN_DAY - MIDNIGHT_OFFSET;
			return 32'(day_start + longint'($urandom_range(4)) - 2);
		end
		if (kind < 90)
			return $urandom_range(32'hFFFF_FFFF, LAST_VALID_SECONDS + 32'd1);
		return $urandom;
	endfunction

	// Offer one request and record its expected calendar once accepted
	task automatic send_stamp(input logic [31:0] secs, input calendar_t want);
		if (!calm) begin
			while ($urandom_range(99) < IDLE_PERCENT) begin
				stamp_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		stamp_ch.valid <= 1'b1;
		stamp_ch.epoch_seconds <= secs;
		@(posedge clk);
		while (!stamp_ch.ready)
			@(posedge clk);
		pending_calendars.push_back(want);
		stamps_sent++;
		if (want.out_of_range)
			late_stamps++;
		if (want.month == 4'd2 && want.day_of_month == 5'd29)
			leap_days++;
	endtask

	task automatic run_random(input int count);
		logic [31:0] secs;
		repeat (count) begin
			secs = pick_stamp();
			send_stamp(secs, calendar_of(secs));
		end
	endtask

	task automatic report_mismatch(input string field, input int unsigned got,
			input int unsigned want);
		mismatch_count++;
		$display("result %0d: %s is %0d, expected %0d", dates_checked, field, got, want);
	endtask

	task automatic check_field(input string field, input int unsigned got,
			input int unsigned want);
		if (got != want)
			report_mismatch(field, got, want);
	endtask

	// Output side: random stalls, a calm stretch, and one long hold-off
	initial begin
		cal_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_outputs) begin
				cal_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_outputs = 1'b0;
			end
			cal_ch.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// Result checker
	always @(posedge clk) begin : check_results
		calendar_t got;
		calendar_t want;
		if (arst_n && cal_ch.valid && cal_ch.ready) begin
			got = {cal_ch.year, cal_ch.month, cal_ch.day_of_month, cal_ch.hour,
				cal_ch.minute, cal_ch.second, cal_ch.out_of_range};
			if (pending_calendars.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = pending_calendars.pop_front();
				check_field("year", got.year, want.year);
				check_field("month", got.month, want.month);
				check_field("day_of_month", got.day_of_month, want.day_of_month);
				check_field("hour", got.hour, want.hour);
				check_field("minute", got.minute, want.minute);
				check_field("second", got.second, want.second);
				check_field("out_of_range", got.out_of_range, want.out_of_range);
			end
			dates_checked++;
		end
	end

	// Stimulus
	initial begin : stimulus
		stamp_row_t row;
		mismatch_count = 0;
		stamps_sent = 0;
		dates_checked = 0;
		late_stamps = 0;
		leap_days = 0;
		calm = 1'b0;
		hold_outputs = 1'b0;
		arst_n = 1'b0;
		stamp_ch.valid = 1'b0;
		stamp_ch.epoch_seconds = '0;

		// epoch, midnight edges, leap days, year ends, top of range
		add_row(32'd0,          1'b1, date_of(2000, 1, 1, 12, 0, 0, 1'b0));
		add_row(32'd43199,      1'b1, date_of(2000, 1, 1, 23, 59, 59, 1'b0));
		add_row(32'd43200,      1'b1, date_of(2000, 1, 2, 0, 0, 0, 1'b0));
		add_row(32'd5054399,    1'b0, '0);
		add_row(32'd5054400,    1'b0, '0);
		add_row(32'd5140800,    1'b0, '0);
		add_row(32'd31492800,   1'b0, '0);
		add_row(32'd31579199,   1'b0, '0);
		add_row(32'd31579200,   1'b0, '0);
		add_row(32'd36676799,   1'b0, '0);
		add_row(32'd36676800,   1'b0, '0);
		add_row(32'd126187199,  1'b0, '0);
		add_row(32'd126187200,  1'b0, '0);
		add_row(32'd131284800,  1'b0, '0);
		add_row(32'h7FFF_FFFF,  1'b0, '0);
		add_row(32'h8000_0000,  1'b0, '0);
		add_row(32'h5555_5555,  1'b0, '0);
		add_row(32'hAAAA_AAAA,  1'b0, '0);
		add_row(32'd3155716798, 1'b0, '0);
		add_row(32'd3155716799, 1'b1, date_of(2099, 12, 31, 23, 59, 59, 1'b0));
		add_row(32'd3155716800, 1'b1, date_of(0, 0, 0, 0, 0, 0, 1'b1));
		add_row(32'hFFFF_FFFF,  1'b1, date_of(0, 0, 0, 18, 28, 15, 1'b1));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			send_stamp(row.secs, row.typed ? row.want : calendar_of(row.secs));
		end

		run_random(250);
		calm = 1'b1;
		run_random(150);
		calm = 1'b0;
		// output held off while requests keep coming
		hold_outputs = 1'b1;
		run_random(60);
		run_random(190);
		stamp_ch.valid <= 1'b0;

		while (pending_calendars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("converted %0d timestamps, %0d results checked", stamps_sent, dates_checked);
		$display("%0d past the range, %0d on a leap day", late_stamps, leap_days);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
